/* hdl/tat_pkg.sv */
// Package for the three-anchor trilateration unit: shared types and constants.
// No dependencies.
package tat_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_MAX   = 3'd1;
    localparam logic [2:0] REG_A0X   = 3'd2;
    localparam logic [2:0] REG_A0Y   = 3'd3;
    localparam logic [2:0] REG_A1X   = 3'd4;
    localparam logic [2:0] REG_A1Y   = 3'd5;
    localparam logic [2:0] REG_A2X   = 3'd6;
    localparam logic [2:0] REG_A2Y   = 3'd7;

    localparam logic [1:0] FIX_OK        = 2'd0;
    localparam logic [1:0] FIX_COLLINEAR = 2'd1;
    localparam logic [1:0] FIX_SAT       = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_COEF,    // A, B, D, E from anchor positions
        OP_SQ,      // squares of positions and distances, one per step
        OP_CF,      // sum squares into C and F
        OP_P1,      // products step 1
        OP_P2,      // products step 2
        OP_P3,      // products step 3
        OP_NUM,     // numerators and denominator
        OP_DIV_X,   // start divide x
        OP_DIV_Y    // start divide y
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] sq_sel;
        logic       div_step;
        logic       clear;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } dp_stat_t;

endpackage

/* hdl/tat_ctrl.sv */
// Sequencer of the trilateration unit: report intake, solve steps, output item.
// Depends on tat_pkg.
module tat_ctrl import tat_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     solve_start,
    input  logic     out_taken,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     out_valid,
    output logic     latch_x,
    output logic     latch_y
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_COEF, ST_SQ, ST_CF, ST_P1, ST_P2, ST_P3, ST_NUM,
        ST_DX, ST_WX, ST_DY, ST_WY, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] sq_reg, sq_next;

    always_comb begin
        state_next = state_reg;
        sq_next    = sq_reg;
        cmd        = '{op: OP_NONE, sq_sel: sq_reg, div_step: 1'b0, clear: 1'b0};
        latch_x    = 1'b0;
        latch_y    = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (solve_start) state_next = ST_COEF;
            ST_COEF: begin
                cmd.op     = OP_COEF;
                sq_next    = '0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op  = OP_SQ;
                sq_next = sq_reg + 4'd1;
                if (sq_reg == 4'd8) state_next = ST_CF;
            end
            ST_CF:  begin cmd.op = OP_CF; state_next = ST_P1; end
            ST_P1:  begin cmd.op = OP_P1; state_next = ST_P2; end
            ST_P2:  begin cmd.op = OP_P2; state_next = ST_P3; end
            ST_P3:  begin cmd.op = OP_P3; state_next = ST_NUM; end
            ST_NUM: begin cmd.op = OP_NUM; state_next = ST_DX; end
            ST_DX: begin
                if (stat.den_zero) begin
                    state_next = ST_OUT;
                    cmd.clear  = 1'b1;
                end else begin
                    cmd.op     = OP_DIV_X;
                    state_next = ST_WX;
                end
            end
            ST_WX: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    latch_x    = 1'b1;
                    state_next = ST_DY;
                end
            end
            ST_DY: begin cmd.op = OP_DIV_Y; state_next = ST_WY; end
            ST_WY: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    latch_y    = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: if (out_taken) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sq_reg    <= '0;
        end else begin
            state_reg <= state_next;
            sq_reg    <= sq_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

/* hdl/tat_datapath.sv */
// Datapath: anchor distances, coefficient products and a radix-2 divider.
// Depends on tat_pkg.
module tat_datapath import tat_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    input  logic               store_en,
    input  logic [1:0]         store_idx,
    input  logic [15:0]        store_val,
    input  logic signed [15:0] ax0, ay0, ax1, ay1, ax2, ay2,
    input  logic               latch_x,
    input  logic               latch_y,
    output dp_stat_t           stat,
    output logic [2:0]         seen,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic [1:0]         fix_status
);

    localparam int SAT_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int DIV_BITS = 58;
    localparam int CNT_W    = 6;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic [15:0]        dist_reg [3];
    logic [2:0]         seen_reg;
    logic signed [17:0] a_reg, b_reg, d_reg, e_reg;
    logic signed [33:0] sq_reg [9];
    logic signed [35:0] c_reg, f_reg;
    logic signed [55:0] ce_reg, fb_reg, af_reg, cd_reg, ae_reg, bd_reg;
    logic signed [56:0] numx_reg, numy_reg, den_reg;
    logic [DIV_BITS-1:0] quo_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg, sat_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [1:0]         st_reg;

    logic signed [16:0] sq_op;
    logic signed [33:0] sq_prod;
    logic [DIV_BITS-1:0] rem_shift;
    logic signed [63:0] q_signed;
    logic signed [15:0] q_clamp;
    logic               q_sat;

    always_comb begin
        case (cmd.sq_sel)
            4'd0: sq_op = 17'(ax0);
            4'd1: sq_op = 17'(ay0);
            4'd2: sq_op = 17'(ax1);
            4'd3: sq_op = 17'(ay1);
            4'd4: sq_op = 17'(ax2);
            4'd5: sq_op = 17'(ay2);
            4'd6: sq_op = $signed({1'b0, dist_reg[0]});
            4'd7: sq_op = $signed({1'b0, dist_reg[1]});
            4'd8: sq_op = $signed({1'b0, dist_reg[2]});
            default: sq_op = '0;
        endcase
        sq_prod = sq_op * sq_op;
    end

    assign rem_shift = {rem_reg[DIV_BITS-2:0], quo_reg[DIV_BITS-1]};

    always_comb begin
        q_signed = neg_reg ? -$signed({6'd0, quo_reg}) : $signed({6'd0, quo_reg});
        q_sat    = 1'b0;
        if (q_signed > SAT_HI) begin
            q_clamp = 16'(SAT_HI);
            q_sat   = 1'b1;
        end else if (q_signed < SAT_LO) begin
            q_clamp = 16'(SAT_LO);
            q_sat   = 1'b1;
        end else begin
            q_clamp = 16'(q_signed);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            cnt_reg  <= '0;
            for (int i = 0; i < 3; i++) dist_reg[i] <= '0;
        end else begin
            if (store_en) begin
                dist_reg[store_idx] <= store_val;
                seen_reg[store_idx] <= 1'b1;
            end
            if (cmd.clear) begin
                seen_reg <= '0;
                for (int i = 0; i < 3; i++) dist_reg[i] <= '0;
            end
            if (cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y) begin
                cnt_reg <= CNT_W'(DIV_BITS);
            end else if (cmd.div_step && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_COEF: begin
                a_reg   <= 18'(2 * (17'(ax1) - 17'(ax0)));
                b_reg   <= 18'(2 * (17'(ay1) - 17'(ay0)));
                d_reg   <= 18'(2 * (17'(ax2) - 17'(ax0)));
                e_reg   <= 18'(2 * (17'(ay2) - 17'(ay0)));
                sat_reg <= 1'b0;
            end
            OP_SQ: sq_reg[cmd.sq_sel] <= sq_prod;
            OP_CF: begin
                c_reg <= 36'(sq_reg[6]) - 36'(sq_reg[7]) - 36'(sq_reg[0]) + 36'(sq_reg[2])
                       - 36'(sq_reg[1]) + 36'(sq_reg[3]);
                f_reg <= 36'(sq_reg[6]) - 36'(sq_reg[8]) - 36'(sq_reg[0]) + 36'(sq_reg[4])
                       - 36'(sq_reg[1]) + 36'(sq_reg[5]);
            end
            OP_P1: begin
                ce_reg <= 56'(c_reg * e_reg);
                fb_reg <= 56'(f_reg * b_reg);
            end
            OP_P2: begin
                af_reg <= 56'(a_reg * f_reg);
                cd_reg <= 56'(c_reg * d_reg);
            end
            OP_P3: begin
                ae_reg <= 56'(a_reg * e_reg);
                bd_reg <= 56'(b_reg * d_reg);
            end
            OP_NUM: begin
                numx_reg <= 57'(ce_reg) - 57'(fb_reg);
                numy_reg <= 57'(af_reg) - 57'(cd_reg);
                den_reg  <= 57'(ae_reg) - 57'(bd_reg);
            end
            OP_DIV_X, OP_DIV_Y: begin
                quo_reg <= (cmd.op == OP_DIV_X)
                    ? (numx_reg[56] ? DIV_BITS'(-numx_reg) : DIV_BITS'(numx_reg))
                    : (numy_reg[56] ? DIV_BITS'(-numy_reg) : DIV_BITS'(numy_reg));
                neg_reg <= ((cmd.op == OP_DIV_X) ? numx_reg[56] : numy_reg[56]) ^ den_reg[56];
                dvs_reg <= den_reg[56] ? DIV_BITS'(-den_reg) : DIV_BITS'(den_reg);
                rem_reg <= '0;
            end
            default: ;
        endcase
        if (cmd.div_step && cnt_reg != '0) begin
            if (rem_shift >= dvs_reg) begin
                rem_reg <= rem_shift - dvs_reg;
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
        if (latch_x) begin
            px_reg  <= q_clamp;
            sat_reg <= q_sat;
        end
        if (latch_y) begin
            py_reg <= q_clamp;
            st_reg <= (sat_reg || q_sat) ? FIX_SAT : FIX_OK;
        end
        if (cmd.clear && !latch_y) begin
            px_reg <= '0;
            py_reg <= '0;
            st_reg <= FIX_COLLINEAR;
        end
    end

    assign stat.den_zero = (den_reg == '0);
    assign stat.div_done = cmd.div_step && (cnt_reg == '0);
    assign seen          = seen_reg;
    assign pos_x         = px_reg;
    assign pos_y         = py_reg;
    assign fix_status    = st_reg;

endmodule

/* hdl/three_anchor_trilateration_unit.sv */
// Three-anchor trilateration unit, top level: config registers, report filter.
// Depends on tat_pkg, tat_ctrl, tat_datapath.
// A non-completing report is just taken; a completing one raises m_valid after the
// flag register, the coefficient step, 9 squares, 5 sum/product steps and two divides,
// or with no divide if collinear, and no report is taken until the result is taken.
// Reset restores register defaults and clears distances and flags.
module three_anchor_trilateration_unit import tat_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_anchor_addr,
    input  logic [15:0]        s_range_mm,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic [1:0]         m_fix_status,
    input  logic               cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0] cfg_reg [NUM_REGS];
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        busy, latch_x, latch_y, solve_reg;
    logic [2:0]  seen;
    logic [16:0] off;
    logic        in_range, hit, accept;
    logic [1:0]  idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_BASE] <= 16'd132;
            cfg_reg[REG_MAX]  <= 16'd20000;
            cfg_reg[REG_A0X]  <= 16'd0;
            cfg_reg[REG_A0Y]  <= 16'd0;
            cfg_reg[REG_A1X]  <= 16'd0;
            cfg_reg[REG_A1Y]  <= 16'd400;
            cfg_reg[REG_A2X]  <= 16'd1000;
            cfg_reg[REG_A2Y]  <= 16'd0;
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign s_ready  = !busy && !solve_reg;
    assign accept   = s_valid && s_ready;
    assign off      = {1'b0, s_anchor_addr} - {1'b0, cfg_reg[REG_BASE]};
    assign in_range = (s_range_mm != '0) && (s_range_mm < cfg_reg[REG_MAX]);
    assign hit      = in_range && (off < 17'd3);
    assign idx      = off[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) solve_reg <= 1'b0;
        else solve_reg <= accept && hit && ((seen | (3'b001 << idx)) == 3'b111);
    end

    tat_ctrl u_ctrl (
        .aclk, .aresetn,
        .solve_start(solve_reg),
        .out_taken(m_valid && m_ready),
        .stat, .cmd, .busy,
        .out_valid(m_valid),
        .latch_x, .latch_y
    );

    tat_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn, .cmd,
        .store_en(accept && hit),
        .store_idx(idx),
        .store_val(s_range_mm),
        .ax0($signed(cfg_reg[REG_A0X])), .ay0($signed(cfg_reg[REG_A0Y])),
        .ax1($signed(cfg_reg[REG_A1X])), .ay1($signed(cfg_reg[REG_A1Y])),
        .ax2($signed(cfg_reg[REG_A2X])), .ay2($signed(cfg_reg[REG_A2Y])),
        .latch_x, .latch_y, .stat, .seen,
        .pos_x(m_pos_x), .pos_y(m_pos_y), .fix_status(m_fix_status)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready) else $error("item taken during solve");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        solve_reg |-> !busy) else $error("solve started while busy");
    a_full_set: assert property (@(posedge aclk) disable iff (!aresetn)
        solve_reg |-> seen == 3'b111) else $error("solve without full set");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fix_status != 2'd3) else $error("bad status");

endmodule
